@@ hdl/pcxrle_pkg.sv @@
// Shared types and constants for the PCX run-length palette decoder.
package pcxrle_pkg;

   // Byte codes at or above this value start a run.
   localparam logic [7:0] RUN_MARK = 8'hC0;

   localparam int PAL_DEPTH = 256;
   localparam int PAL_WIDTH = 24;

   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   // Register indexes, taken from paddr[3:2].
   localparam logic [1:0] CSR_IMAGE_WIDTH    = 2'd0;
   localparam logic [1:0] CSR_IMAGE_HEIGHT   = 2'd1;
   localparam logic [1:0] CSR_BYTES_PER_LINE = 2'd2;

   // Input word function codes.
   localparam logic FUNC_IMAGE_BYTE = 1'b0;
   localparam logic FUNC_PAL_WRITE  = 1'b1;

   typedef struct packed {
      logic        func;
      logic [7:0]  code_byte;
      logic [7:0]  entry_index;
      logic [23:0] entry_rgb;
   } req_word_type;

   typedef struct packed {
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [15:0] column;
      logic [15:0] out_row;
      logic        last;
   } rsp_word_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_RUN,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic pal_wr;
      logic take_run;
      logic take_lit;
      logic set_run;
      logic load_color;
      logic step;
      logic hold_new;
      logic push_held;
      logic push_last;
   } ctl_type;

endpackage

@@ hdl/pcx_rle_palette_decoder_unit.sv @@
// Top level of the PCX 8-bit run-length decoder with its RGB palette.
//
//   Channel  Direction  Handshake               Word
//   req      in         req_valid / req_ready   req_word_type (byte or palette write)
//   rsp      out        rsp_valid / rsp_ready   rsp_word_type (one visible pixel)
//   csr      in/out     APB psel/penable/pready 32-bit registers at 0x0, 0x4, 0x8
//
// A palette write, a run marker byte, a zero-length run value and any image byte
// after the last scanline leave the sequencer idle, ready again the next cycle. A
// literal byte or a run value of N copies is accepted in idle, has its palette
// read registered in load, steps in run, one position per cycle from the single
// position stepper unless the rsp side stalls, until the sequencer sees the count
// run out, and releases its final pixel with last in flush. A run that reaches the
// end of the image stops stepping there and is released the same way. A pixel is
// held back one position so that last can be set once the item's final visible
// pixel is known; a stalled rsp side pauses the stepper only when a second visible
// pixel is ready to move out, and the release waits until the result register is
// free. Reset is synchronous, clears the decode state but not the color, held and
// result payloads, and sets the three registers to one; the palette is not cleared.
module pcx_rle_palette_decoder_unit (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  pcxrle_pkg::req_word_type                  req_data,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output pcxrle_pkg::rsp_word_type                  rsp_data,
   input  logic                                      csr_psel,
   input  logic                                      csr_penable,
   input  logic                                      csr_pwrite,
   input  logic [pcxrle_pkg::CSR_ADDR_BITS-1:0]      csr_paddr,
   input  logic [pcxrle_pkg::CSR_DATA_BITS-1:0]      csr_pwdata,
   output logic [pcxrle_pkg::CSR_DATA_BITS-1:0]      csr_prdata,
   output logic                                      csr_pready
);

   import pcxrle_pkg::*;

   // Configuration registers.
   logic [15:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic [15:0] bpl_ff, bpl_in;

   // Decode state.
   state_type    state_ff, state_in;
   logic         pending_ff, pending_in;
   logic [5:0]   run_len_ff, run_len_in;
   logic [5:0]   count_ff, count_in;
   logic [15:0]  line_pos_ff, line_pos_in;
   logic [15:0]  scan_ff, scan_in;
   logic         done_ff, done_in;
   logic [23:0]  color_ff, color_in;
   rsp_word_type held_ff, held_in;
   logic         held_valid_ff, held_valid_in;
   rsp_word_type rsp_data_ff, rsp_data_in;
   logic         rsp_valid_ff, rsp_valid_in;

   ctl_type      ctl;
   logic         csr_wr;
   logic [1:0]   csr_index;
   logic         accept;
   logic         visible;
   logic         line_end;
   logic [15:0]  scan_inc;
   logic [15:0]  row;
   logic         out_free;
   logic         step_ok;
   logic         starts_pixels;
   logic [23:0]  pal_rd_data;

   // Palette store: written by palette words, its read taken once per pixel-producing byte.
   pcxrle_ram #(
      .Width (PAL_WIDTH),
      .Depth (PAL_DEPTH)
   ) u_palette (
      .clock   (clock),
      .wr_en   (ctl.pal_wr),
      .wr_addr (req_data.entry_index),
      .wr_data (req_data.entry_rgb),
      .rd_addr (req_data.code_byte),
      .rd_data (pal_rd_data)
   );

   // Register port: writes land on the access cycle; pready is tied high.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[3:2];

   always_comb begin
      case (csr_index)
         CSR_IMAGE_WIDTH:    csr_prdata = {16'd0, width_ff};
         CSR_IMAGE_HEIGHT:   csr_prdata = {16'd0, height_ff};
         CSR_BYTES_PER_LINE: csr_prdata = {16'd0, bpl_ff};
         default:            csr_prdata = '0;
      endcase
   end

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      bpl_in    = bpl_ff;
      if (csr_wr) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:    width_in  = csr_pwdata[15:0];
            CSR_IMAGE_HEIGHT:   height_in = csr_pwdata[15:0];
            CSR_BYTES_PER_LINE: bpl_in    = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   // Position stepper: per cycle, a compare decides visibility, an add and compare
   // the line end, and a subtraction the bottom-up row of the current position.
   assign visible  = line_pos_ff < width_ff;
   assign line_end = ({1'b0, line_pos_ff} + 17'd1) >= {1'b0, bpl_ff};
   assign scan_inc = scan_ff + 16'd1;
   assign row      = height_ff - 16'd1 - scan_ff;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // A visible position can only be taken when the held pixel has somewhere to go.
   assign step_ok = !(visible && held_valid_ff && !out_free);

   // An image byte that leads to at least one position step.
   assign starts_pixels = (req_data.func == FUNC_IMAGE_BYTE) && !done_ff &&
                          ((pending_ff && (run_len_ff != 6'd0)) ||
                           (!pending_ff && (req_data.code_byte < RUN_MARK)));

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && starts_pixels) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            state_in = ST_RUN;
         end
         ST_RUN: begin
            if ((count_ff == 6'd0) || done_ff) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!held_valid_ff || out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control strobes.
   always_comb begin
      ctl = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.func == FUNC_PAL_WRITE) begin
                  ctl.pal_wr = 1'b1;
               end else if (!done_ff) begin
                  if (pending_ff) begin
                     ctl.take_run = 1'b1;
                  end else if (req_data.code_byte < RUN_MARK) begin
                     ctl.take_lit = 1'b1;
                  end else begin
                     ctl.set_run = 1'b1;
                  end
               end
            end
         end
         ST_LOAD: begin
            ctl.load_color = 1'b1;
         end
         ST_RUN: begin
            if ((count_ff != 6'd0) && !done_ff && step_ok) begin
               ctl.step = 1'b1;
               if (visible) begin
                  ctl.hold_new  = 1'b1;
                  ctl.push_held = held_valid_ff;
               end
            end
         end
         ST_FLUSH: begin
            if (held_valid_ff && out_free) begin
               ctl.push_held = 1'b1;
               ctl.push_last = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // Datapath next values.
   always_comb begin
      pending_in    = pending_ff;
      run_len_in    = run_len_ff;
      count_in      = count_ff;
      line_pos_in   = line_pos_ff;
      scan_in       = scan_ff;
      done_in       = done_ff;
      color_in      = color_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff;

      if (ctl.take_run) begin
         pending_in = 1'b0;
         count_in   = run_len_ff;
         run_len_in = 6'd0;
      end
      if (ctl.take_lit) begin
         count_in = 6'd1;
      end
      if (ctl.set_run) begin
         pending_in = 1'b1;
         run_len_in = req_data.code_byte[5:0];
      end
      if (ctl.load_color) begin
         color_in = pal_rd_data;
      end

      if (ctl.step) begin
         count_in = count_ff - 6'd1;
         if (line_end) begin
            line_pos_in = 16'd0;
            scan_in     = scan_inc;
            if ((scan_inc == 16'd0) || (scan_inc >= height_ff)) begin
               done_in = 1'b1;
            end
         end else begin
            line_pos_in = line_pos_ff + 16'd1;
         end
      end

      if (ctl.push_held) begin
         rsp_valid_in     = 1'b1;
         rsp_data_in      = held_ff;
         rsp_data_in.last = ctl.push_last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (ctl.hold_new) begin
         held_in.red     = color_ff[23:16];
         held_in.green   = color_ff[15:8];
         held_in.blue    = color_ff[7:0];
         held_in.column  = line_pos_ff;
         held_in.out_row = row;
         held_in.last    = 1'b0;
         held_valid_in   = 1'b1;
      end else if (ctl.push_last) begin
         held_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= 16'd1;
         height_ff     <= 16'd1;
         bpl_ff        <= 16'd1;
         state_ff      <= ST_IDLE;
         pending_ff    <= 1'b0;
         run_len_ff    <= 6'd0;
         count_ff      <= 6'd0;
         line_pos_ff   <= 16'd0;
         scan_ff       <= 16'd0;
         done_ff       <= 1'b0;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         width_ff      <= width_in;
         height_ff     <= height_in;
         bpl_ff        <= bpl_in;
         state_ff      <= state_in;
         pending_ff    <= pending_in;
         run_len_ff    <= run_len_in;
         count_ff      <= count_in;
         line_pos_ff   <= line_pos_in;
         scan_ff       <= scan_in;
         done_ff       <= done_in;
         held_valid_ff <= held_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      color_ff    <= color_in;
      held_ff     <= held_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ hdl/pcxrle_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
module pcxrle_ram #(
   parameter int Width = 24,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/pcxrle_checker.sv @@
// Port-level checks for the PCX run-length palette decoder, bound to the top level.
module pcxrle_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input pcxrle_pkg::req_word_type             req_data,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input pcxrle_pkg::rsp_word_type             rsp_data,
   input logic                                 csr_psel,
   input logic                                 csr_penable,
   input logic                                 csr_pwrite,
   input logic [pcxrle_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input logic [pcxrle_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   input logic [pcxrle_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   input logic                                 csr_pready
);

   import pcxrle_pkg::*;

   // A result word that is not taken stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp word changed or dropped while stalled");

   // Reset empties the result register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // A palette write leaves the block ready again in the next cycle.
   a_pal_one_cycle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.func == FUNC_PAL_WRITE) |=> req_ready)
      else $error("not ready after a palette write");

   // A palette write never produces a pixel.
   a_pal_no_pixel: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.func == FUNC_PAL_WRITE) && !rsp_valid
      |=> !rsp_valid)
      else $error("pixel produced by a palette write");

endmodule

bind pcx_rle_palette_decoder_unit pcxrle_checker u_pcxrle_checker (.*);

@@ tb/tb_pcx_rle_palette_decoder_unit.sv @@
// Self-checking testbench for the PCX run-length palette decoder unit.
module tb_pcx_rle_palette_decoder_unit;
   import pcxrle_pkg::*;

   // A literal or a 63-copy run is meant to finish inside the block well within this
   // many quiet cycles after the last pixel, so nothing is still in flight.
   localparam int SETTLE_CYCLES = 100;
   // Cycles without any word moving on either channel before the run is abandoned.
   localparam int STALL_LIMIT   = 3000;
   // Chance, in percent, that a side idles in a given cycle.
   localparam int IDLE_PERCENT  = 17;

   // How a row of the directed part is checked: by the decoder model, by
   // demanding that it makes no pixel, or against one pixel typed into the row.
   typedef enum {ROW_MODEL, ROW_NONE, ROW_PIXEL} row_kind_type;

   typedef struct {
      row_kind_type kind;
      req_word_type word;
      rsp_word_type pixel;
   } stim_row_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   req_word_type             req_data;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   rsp_word_type             rsp_data;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   pcx_rle_palette_decoder_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Decoder model state. The registers mirror what has been written over the
   // configuration port; the rest follows the block's decode state word by word.
   logic [15:0] cfg_width;
   logic [15:0] cfg_height;
   logic [15:0] cfg_bpl;
   logic [23:0] palette [PAL_DEPTH];
   bit          palette_written [PAL_DEPTH];
   bit          run_wait;
   logic [5:0]  run_len;
   logic [15:0] line_pos;
   logic [15:0] line_no;
   bit          img_done;

   // Pixels the block still owes, oldest first, and the pixels of the word
   // that was just accepted.
   rsp_word_type expected_pixels [$];
   rsp_word_type decoded_batch [$];
   stim_row_type directed_rows [$];
   rsp_word_type want_px;

   // When set, neither side idles. The sender keeps valid up between words
   // only while req_up says a word is on the bus.
   bit steady = 1'b0;
   bit req_up = 1'b0;

   int mismatch_count = 0;
   int pixels_checked = 0;
   int words_sent     = 0;
   int pal_writes     = 0;
   int run_markers    = 0;
   int ignored_bytes  = 0;
   int cfg_writes     = 0;
   int unsigned quiet_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("mismatch at %0t: %s", $time, what);
   endtask

   // Works out the pixels that one accepted word causes and leaves them in
   // decoded_batch, with last set on the final one.
   task automatic decode_word(input req_word_type w);
      int unsigned  count;
      int unsigned  k;
      rsp_word_type px;
      decoded_batch.delete();
      if (w.func == FUNC_PAL_WRITE) begin
         // Palette loads never touch the decode position.
         palette[w.entry_index] = w.entry_rgb;
         palette_written[w.entry_index] = 1'b1;
         pal_writes++;
         return;
      end
      // Once the last scanline is complete every image byte is dropped for good.
      if (img_done) begin
         ignored_bytes++;
         return;
      end
      if (run_wait) begin
         // This byte is the color index of the pending run; a count of zero
         // swallows it without a pixel.
         run_wait = 1'b0;
         count = run_len;
         run_len = '0;
      end else if (w.code_byte < RUN_MARK) begin
         count = 1;
      end else begin
         run_wait = 1'b1;
         run_len = w.code_byte[5:0];
         run_markers++;
         return;
      end
      for (k = 0; k < count && !img_done; k++) begin
         // Positions past the visible width are padding: they move the line
         // along but make no pixel.
         if (line_pos < cfg_width) begin
            px.red     = palette[w.code_byte][23:16];
            px.green   = palette[w.code_byte][15:8];
            px.blue    = palette[w.code_byte][7:0];
            px.column  = line_pos;
            px.out_row = cfg_height - 16'd1 - line_no;
            px.last    = 1'b0;
            decoded_batch.push_back(px);
         end
         // The line test is done in full integer width, so a length register
         // lowered under the current position ends the line at once.
         if (int'(line_pos) + 1 >= int'(cfg_bpl)) begin
            line_pos = '0;
            line_no = line_no + 16'd1;
            if (line_no == 16'd0 || line_no >= cfg_height)
               img_done = 1'b1;
         end else begin
            line_pos = line_pos + 16'd1;
         end
      end
      if (decoded_batch.size() != 0) begin
         px = decoded_batch.pop_back();
         px.last = 1'b1;
         decoded_batch.push_back(px);
      end
   endtask

   // Presents one word, holds it until the block takes it, then queues the
   // pixels it should cause. Random idle cycles come before the word.
   task automatic send_word(input req_word_type w, input row_kind_type kind,
                            input rsp_word_type typed_px);
      while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         if (req_up) begin
            req_valid <= 1'b0;
            req_up = 1'b0;
         end
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      req_up = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
      decode_word(w);
      case (kind)
         ROW_MODEL: begin
            foreach (decoded_batch[i]) expected_pixels.push_back(decoded_batch[i]);
         end
         ROW_NONE: begin
            if (decoded_batch.size() != 0)
               report_mismatch($sformatf("directed word %0d should make no pixel",
                                         words_sent));
         end
         ROW_PIXEL: begin
            if (decoded_batch.size() != 1)
               report_mismatch($sformatf("directed word %0d should make one pixel",
                                         words_sent));
            expected_pixels.push_back(typed_px);
         end
         default: ;
      endcase
   endtask

   task automatic send_palette(input logic [7:0] idx, input logic [23:0] rgb);
      req_word_type w;
      w.func        = FUNC_PAL_WRITE;
      w.code_byte   = 8'($urandom_range(255));
      w.entry_index = idx;
      w.entry_rgb   = rgb;
      send_word(w, ROW_MODEL, '0);
   endtask

   task automatic send_image(input logic [7:0] b);
      req_word_type w;
      // A byte that will be taken as a color index must find its palette entry
      // loaded, so an unloaded entry is written first with a random color.
      if ((b < RUN_MARK || run_wait) && !palette_written[b])
         send_palette(b, 24'($urandom));
      w.func        = FUNC_IMAGE_BYTE;
      w.code_byte   = b;
      w.entry_index = 8'($urandom_range(255));
      w.entry_rgb   = 24'($urandom);
      send_word(w, ROW_MODEL, '0);
   endtask

   // Drops valid and waits until every queued pixel has arrived; with settle
   // set it also waits out anything still working inside the block.
   task automatic drain(input bit settle);
      if (req_up) begin
         req_valid <= 1'b0;
         req_up = 1'b0;
      end
      do @(posedge clock); while (expected_pixels.size() != 0);
      if (settle) repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One APB transfer: a setup cycle, then an access cycle held until pready.
   task automatic csr_access(input logic wr, input logic [1:0] idx,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_check(input logic [1:0] idx, input logic [15:0] want);
      logic [31:0] got;
      csr_access(1'b0, idx, '0, got);
      if (got[15:0] !== want)
         report_mismatch($sformatf("register %0d reads %0h, want %0h", idx, got, want));
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [15:0] val);
      logic [31:0] unused;
      csr_access(1'b1, idx, {16'd0, val}, unused);
      case (idx)
         CSR_IMAGE_WIDTH:    cfg_width  = val;
         CSR_IMAGE_HEIGHT:   cfg_height = val;
         CSR_BYTES_PER_LINE: cfg_bpl    = val;
         default: ;
      endcase
      cfg_writes++;
      csr_check(idx, val);
   endtask

   task automatic add_row(input row_kind_type kind, input logic func, input logic [7:0] code,
                          input logic [7:0] idx, input logic [23:0] rgb,
                          input rsp_word_type px);
      stim_row_type r;
      r.kind  = kind;
      r.word  = req_word_type'{func, code, idx, rgb};
      r.pixel = px;
      directed_rows.push_back(r);
   endtask

   // Mostly well-formed streams of literals, runs and palette loads, with some
   // lone run markers and palette loads wedged between a marker and its value.
   task automatic random_stream(input int n_words, input int max_run);
      int         stop_at;
      int         pick;
      logic [5:0] len;
      stop_at = words_sent + n_words;
      while (words_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 18) begin
            send_palette(8'($urandom_range(255)), 24'($urandom));
         end else if (pick < 55) begin
            send_image(8'($urandom_range(RUN_MARK - 1)));
         end else if (pick < 93) begin
            case ($urandom_range(9))
               0: len = 6'd63;
               1: len = 6'd0;
               default: len = 6'($urandom_range(max_run));
            endcase
            send_image(RUN_MARK + len);
            send_image(8'($urandom_range(255)));
         end else begin
            send_image(RUN_MARK | 8'($urandom_range(63)));
            if ($urandom_range(1)) send_palette(8'($urandom_range(255)), 24'($urandom));
         end
         // Now and then hold the sender back until the block has caught up.
         if ($urandom_range(59) == 0) drain(1'b0);
      end
   endtask

   // Result side: every pixel taken is checked field by field against the
   // oldest pixel still owed. Ready is redrawn every cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            report_mismatch($sformatf("pixel at column %0d row %0d with none owed",
                                      rsp_data.column, rsp_data.out_row));
         end else begin
            want_px = expected_pixels.pop_front();
            pixels_checked++;
            if (rsp_data.red !== want_px.red)
               report_mismatch($sformatf("pixel %0d red %0h, want %0h",
                                         pixels_checked, rsp_data.red, want_px.red));
            if (rsp_data.green !== want_px.green)
               report_mismatch($sformatf("pixel %0d green %0h, want %0h",
                                         pixels_checked, rsp_data.green, want_px.green));
            if (rsp_data.blue !== want_px.blue)
               report_mismatch($sformatf("pixel %0d blue %0h, want %0h",
                                         pixels_checked, rsp_data.blue, want_px.blue));
            if (rsp_data.column !== want_px.column)
               report_mismatch($sformatf("pixel %0d column %0d, want %0d",
                                         pixels_checked, rsp_data.column, want_px.column));
            if (rsp_data.out_row !== want_px.out_row)
               report_mismatch($sformatf("pixel %0d row %0d, want %0d",
                                         pixels_checked, rsp_data.out_row, want_px.out_row));
            if (rsp_data.last !== want_px.last)
               report_mismatch($sformatf("pixel %0d last %b, want %b",
                                         pixels_checked, rsp_data.last, want_px.last));
         end
      end
      rsp_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
   end

   // Watchdog: a long spell in which no word moves on either channel means
   // the block has hung or lost something.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_data    <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      cfg_width  = 16'd1;
      cfg_height = 16'd1;
      cfg_bpl    = 16'd1;
      run_wait   = 1'b0;
      run_len    = '0;
      line_pos   = '0;
      line_no    = '0;
      img_done   = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // All three registers come out of reset at one. With those values the
      // first pixel would end the image, so the geometry is set before any
      // image byte: three visible columns, one padding column, tall image.
      csr_check(CSR_IMAGE_WIDTH, 16'd1);
      csr_check(CSR_IMAGE_HEIGHT, 16'd1);
      csr_check(CSR_BYTES_PER_LINE, 16'd1);
      csr_write(CSR_IMAGE_WIDTH, 16'd3);
      csr_write(CSR_IMAGE_HEIGHT, 16'hFFFF);
      csr_write(CSR_BYTES_PER_LINE, 16'd4);

      // Directed part. Palette entries at both ends of the index range and of
      // the color range are loaded first. Scanline 0 lands on row 0xFFFE.
      add_row(ROW_NONE, FUNC_PAL_WRITE, 8'h00, 8'h00, 24'h000000, '0);
      add_row(ROW_NONE, FUNC_PAL_WRITE, 8'hFF, 8'hFF, 24'hFFFFFF, '0);
      add_row(ROW_NONE, FUNC_PAL_WRITE, 8'h00, 8'hBF, 24'h123456, '0);
      add_row(ROW_NONE, FUNC_PAL_WRITE, 8'h00, 8'h80, 24'hA5C3E1, '0);
      // Literals fill the three visible columns of scanline 0.
      add_row(ROW_PIXEL, FUNC_IMAGE_BYTE, 8'h00, 8'h00, 24'h0,
              rsp_word_type'{8'h00, 8'h00, 8'h00, 16'd0, 16'hFFFE, 1'b1});
      add_row(ROW_PIXEL, FUNC_IMAGE_BYTE, 8'hBF, 8'h00, 24'h0,
              rsp_word_type'{8'h12, 8'h34, 8'h56, 16'd1, 16'hFFFE, 1'b1});
      add_row(ROW_PIXEL, FUNC_IMAGE_BYTE, 8'h80, 8'h00, 24'h0,
              rsp_word_type'{8'hA5, 8'hC3, 8'hE1, 16'd2, 16'hFFFE, 1'b1});
      // The fourth position is padding: dropped, and it closes the scanline.
      add_row(ROW_NONE, FUNC_IMAGE_BYTE, 8'h00, 8'h00, 24'h0, '0);
      // A zero-length run eats its value byte and makes nothing.
      add_row(ROW_NONE, FUNC_IMAGE_BYTE, 8'hC0, 8'h00, 24'h0, '0);
      add_row(ROW_NONE, FUNC_IMAGE_BYTE, 8'hFF, 8'h00, 24'h0, '0);
      add_row(ROW_PIXEL, FUNC_IMAGE_BYTE, 8'h00, 8'h00, 24'h0,
              rsp_word_type'{8'h00, 8'h00, 8'h00, 16'd0, 16'hFFFD, 1'b1});
      // The longest run, carried over many scanlines and padding positions.
      add_row(ROW_NONE, FUNC_IMAGE_BYTE, 8'hFF, 8'h00, 24'h0, '0);
      add_row(ROW_MODEL, FUNC_IMAGE_BYTE, 8'hFF, 8'h00, 24'h0, '0);
      // A palette load between a run marker and its value.
      add_row(ROW_NONE, FUNC_IMAGE_BYTE, 8'hC5, 8'h00, 24'h0, '0);
      add_row(ROW_NONE, FUNC_PAL_WRITE, 8'h00, 8'h7F, 24'h0F0F0F, '0);
      add_row(ROW_MODEL, FUNC_IMAGE_BYTE, 8'h7F, 8'h00, 24'h0, '0);
      // A run value at or above the marker threshold is still just a color.
      add_row(ROW_NONE, FUNC_PAL_WRITE, 8'h00, 8'hC0, 24'h00FF00, '0);
      add_row(ROW_NONE, FUNC_IMAGE_BYTE, 8'hC1, 8'h00, 24'h0, '0);
      add_row(ROW_MODEL, FUNC_IMAGE_BYTE, 8'hC0, 8'h00, 24'h0, '0);
      add_row(ROW_NONE, FUNC_IMAGE_BYTE, 8'hC3, 8'h00, 24'h0, '0);
      add_row(ROW_MODEL, FUNC_IMAGE_BYTE, 8'h80, 8'h00, 24'h0, '0);
      foreach (directed_rows[i])
         send_word(directed_rows[i].word, directed_rows[i].kind, directed_rows[i].pixel);
      drain(1'b1);

      // Widest geometry: one scanline can hold every pixel of this phase.
      csr_write(CSR_IMAGE_WIDTH, 16'hFFFF);
      csr_write(CSR_IMAGE_HEIGHT, 16'hFFFF);
      csr_write(CSR_BYTES_PER_LINE, 16'hFFFF);
      random_stream(130, 63);
      drain(1'b1);

      // Narrowest geometry, run with both sides always ready. Lowering the
      // line length under the current position ends that line at the next
      // pixel; after that every pixel is a scanline of its own.
      steady = 1'b1;
      csr_write(CSR_IMAGE_WIDTH, 16'd1);
      csr_write(CSR_BYTES_PER_LINE, 16'd1);
      random_stream(110, 40);
      drain(1'b1);
      steady = 1'b0;

      // Short lines with padding, so runs wrap often.
      csr_write(CSR_IMAGE_WIDTH, 16'd5);
      csr_write(CSR_BYTES_PER_LINE, 16'd7);
      random_stream(140, 20);
      drain(1'b1);

      // Dropping the height under the current scanline: rows wrap around until
      // the line ends, then the image is finished and the rest of a run is lost.
      csr_write(CSR_IMAGE_HEIGHT, 16'd1);
      random_stream(15, 30);
      while (!img_done) send_image(8'($urandom_range(RUN_MARK - 1)));
      // Bytes after the image end must all be ignored.
      repeat (10) send_image(8'($urandom_range(255)));
      drain(1'b1);

      if (expected_pixels.size() != 0)
         report_mismatch($sformatf("%0d pixels never arrived", expected_pixels.size()));
      $display("Sent %0d words: %0d palette loads, %0d run markers, %0d bytes after image end.",
               words_sent, pal_writes, run_markers, ignored_bytes);
      $display("Checked %0d pixels across %0d register writes, widths and lengths 1 to 65535.",
               pixels_checked, cfg_writes);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
